### src/p2mp_pkg.sv
// p2mp_pkg: shared types and constants for pow2_mod_p_squared_core.
// No dependencies.
`default_nettype none
package p2mp_pkg;
  localparam int unsigned W = 64;
  typedef logic [W-1:0] word_t;

  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
    word_t m;
  } mm_req_t;

  typedef struct packed {
    logic  done;
    word_t q;
    word_t r;
  } mm_rsp_t;
endpackage
`default_nettype wire

### src/p2mp_muldiv.sv
// p2mp_muldiv: shared unit computing q, r of (a*b) div/mod m, with a*b < m*2^64.
// Multiply 32x32 per cycle over the four partial products, then restoring divide one bit per cycle.
// Depends on p2mp_pkg.
`default_nettype none
module p2mp_muldiv (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire p2mp_pkg::mm_req_t req_i,
  output p2mp_pkg::mm_rsp_t     rsp_o
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;

  logic [1:0] st_q, st_d;
  logic [6:0] cnt_q, cnt_d;
  logic [127:0] prod_q, prod_d;
  p2mp_pkg::word_t a_q, b_q, m_q, rem_q, rem_d, quo_q, quo_d, lo_q, lo_d;
  logic done_q, done_d;
  logic [31:0] opa, opb;
  logic [63:0] pp;
  logic [64:0] sh;
  logic [64:0] sub;

  always_comb begin
    unique case (cnt_q[1:0])
      2'd0: begin opa = a_q[31:0];  opb = b_q[31:0];  end
      2'd1: begin opa = a_q[31:0];  opb = b_q[63:32]; end
      2'd2: begin opa = a_q[63:32]; opb = b_q[31:0];  end
      default: begin opa = a_q[63:32]; opb = b_q[63:32]; end
    endcase
  end
  assign pp = opa * opb;
  assign sh = {rem_q, lo_q[63]};
  assign sub = sh - {1'b0, m_q};

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; prod_d = prod_q; rem_d = rem_q;
    quo_d = quo_q; lo_d = lo_q; done_d = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (req_i.start) begin
          st_d = StMul; cnt_d = '0; prod_d = '0; quo_d = '0;
        end
      end
      StMul: begin
        unique case (cnt_q[1:0])
          2'd0: prod_d = prod_q + {64'd0, pp};
          2'd1, 2'd2: prod_d = prod_q + {32'd0, pp, 32'd0};
          default: prod_d = prod_q + {pp, 64'd0};
        endcase
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[1:0] == 2'd3) begin
          st_d = StDiv; cnt_d = '0;
          rem_d = prod_d[127:64]; lo_d = prod_d[63:0];
        end
      end
      StDiv: begin
        lo_d = {lo_q[62:0], 1'b0};
        if (!sub[64]) begin
          rem_d = sub[63:0]; quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = sh[63:0]; quo_d = {quo_q[62:0], 1'b0};
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          st_d = StIdle; done_d = 1'b1;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cnt_q <= '0; done_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d; rem_q <= rem_d; quo_q <= quo_d; lo_q <= lo_d;
    if (st_q == StIdle && req_i.start) begin
      a_q <= req_i.a; b_q <= req_i.b; m_q <= req_i.m;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q = quo_q;
  assign rsp_o.r = rem_q;
endmodule
`default_nettype wire

### src/pow2_mod_p_squared_core.sv
// pow2_mod_p_squared_core: 2^(p-1) mod p^2 as base-p digits l + h*p.
// Depends on p2mp_pkg and p2mp_muldiv.
//
// Usage:
//  - Input channel: candidate_prime_i with in_valid_i/in_ready_o. One beat per item.
//  - Output channel: result fields with out_valid_o/out_ready_i, one beat per item.
//  - An item scans all 64 exponent bits: per bit two (mul, div) passes on the
//    shared unit, plus an optional double step (StDbl) and a bit advance
//    (StNext). Items are taken one at a time, since there is a single
//    multiply/divide unit. Invalid p skips the scan and goes straight to the
//    output state.
//  - in_ready_o is high only when idle and the output register is empty.
//  - The result waits in the output register while out_ready_i is low; no
//    new item is taken until it is delivered.
//  - Reset (rst_ni low, async) returns to idle with no result pending.
`default_nettype none
module pow2_mod_p_squared_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] candidate_prime_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      residue_low_o,
  output logic [63:0]      residue_high_o,
  output logic             fermat_holds_o,
  output logic signed [63:0] signed_quotient_o,
  output logic             input_invalid_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSq1  = 3'd1;
  localparam logic [2:0] StSq2  = 3'd2;
  localparam logic [2:0] StDbl  = 3'd3;
  localparam logic [2:0] StNext = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;
  localparam logic [2:0] StW1   = 3'd6;
  localparam logic [2:0] StW2   = 3'd7;

  logic [2:0] st_q, st_d;
  logic [5:0] bit_q, bit_d;
  p2mp_pkg::word_t p_q, l_q, l_d, h_q, h_d, q1_q, q1_d, r1_q, r1_d;
  logic ov_q, ov_d;
  p2mp_pkg::mm_req_t req;
  p2mp_pkg::mm_rsp_t rsp;
  p2mp_pkg::word_t n;
  p2mp_pkg::word_t t, hd, ld;
  logic carry;

  p2mp_muldiv u_md (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_o(rsp));

  function automatic p2mp_pkg::word_t addm(p2mp_pkg::word_t a, p2mp_pkg::word_t b,
                                           p2mp_pkg::word_t m);
    p2mp_pkg::word_t d;
    d = m - b;
    return (a >= d) ? a - d : a + b;
  endfunction

  assign n = p_q - 64'd1;
  assign in_ready_o = (st_q == StIdle) && !ov_q;
  assign t = addm(rsp.r, rsp.r, p_q);
  assign carry = l_q >= (p_q - l_q);
  assign ld = addm(l_q, l_q, p_q);
  assign hd = addm(addm(h_q, h_q, p_q), {63'd0, carry}, p_q);

  always_comb begin
    st_d = st_q; bit_d = bit_q; l_d = l_q; h_d = h_q; q1_d = q1_q; r1_d = r1_q;
    ov_d = ov_q;
    req.start = 1'b0; req.a = l_q; req.b = l_q; req.m = p_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          l_d = 64'd1; h_d = '0; bit_d = 6'd63;
          if (candidate_prime_i < 64'd3 || !candidate_prime_i[0]) st_d = StOut;
          else st_d = StSq1;
        end
      end
      StSq1: begin
        req.start = 1'b1; st_d = StW1;
      end
      StW1: begin
        if (rsp.done) begin
          q1_d = rsp.q; r1_d = rsp.r; st_d = StSq2;
        end
      end
      StSq2: begin
        req.start = 1'b1; req.b = h_q; st_d = StW2;
      end
      StW2: begin
        if (rsp.done) begin
          l_d = r1_q; h_d = addm(q1_q, t, p_q); st_d = StDbl;
        end
      end
      StDbl: begin
        if (n[bit_q]) begin
          l_d = ld; h_d = hd;
        end
        st_d = StNext;
      end
      StNext: begin
        bit_d = bit_q - 6'd1;
        st_d = (bit_q == 6'd0) ? StOut : StSq1;
      end
      StOut: begin
        ov_d = 1'b1; st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ov_q <= 1'b0; bit_q <= '0;
    end else begin
      st_q <= st_d; ov_q <= ov_d; bit_q <= bit_d;
    end
  end

  logic inv_q;
  always_ff @(posedge clk_i) begin
    l_q <= l_d; h_q <= h_d; q1_q <= q1_d; r1_q <= r1_d;
    if (st_q == StIdle && in_valid_i && in_ready_o) begin
      p_q <= candidate_prime_i;
      inv_q <= candidate_prime_i < 64'd3 || !candidate_prime_i[0];
    end
    if (st_q == StOut) begin
      residue_low_o <= inv_q ? '0 : l_q;
      residue_high_o <= inv_q ? '0 : h_q;
      fermat_holds_o <= !inv_q && (l_q == 64'd1);
      signed_quotient_o <= inv_q ? '0 :
        ((h_q > {1'b0, p_q[63:1]}) ? h_q - p_q : h_q);
      input_invalid_o <= inv_q;
    end
  end

  assign out_valid_o = ov_q;

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> !in_ready_o) else $error("ready while busy");
  a_out_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StOut) |=> out_valid_o) else $error("result lost");
  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("accept with pending result");
endmodule
`default_nettype wire
